[hdl/nhtl_pkg.sv]
`default_nettype none
package nhtl_pkg;

    localparam int SLOT_COUNT   = 1024;
    localparam int MAX_ENTRIES  = 512;
    localparam int MAX_NAME_LEN = 32;

    localparam int SLOT_W  = $clog2(SLOT_COUNT);
    localparam int SLOTV_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W   = $clog2(MAX_ENTRIES);
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int LEN_W   = $clog2(MAX_NAME_LEN + 1);
    localparam int POS_W   = $clog2(MAX_NAME_LEN);
    localparam int CHAR_AW = $clog2(MAX_ENTRIES * MAX_NAME_LEN);
    localparam int ID_W    = 15;
    localparam int RES_W   = 16;

    localparam logic [31:0] HASH_BASIS = 32'd2166136261;
    localparam logic [31:0] HASH_PRIME = 32'd16777619;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_LONG = 2'd3;

    localparam logic signed [RES_W-1:0] RES_NONE = -16'sd1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_SLOT_RD,
        S_SLOT_CHK,
        S_LEN_CHK,
        S_CHR_CHK,
        S_COPY,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       push;
        logic       clear;
        logic [7:0] name_byte;
    } t_nb_ctrl;

    typedef struct packed {
        logic [31:0]      hash;
        logic [LEN_W-1:0] len;
        logic             overlong;
    } t_nb_stat;

endpackage
`default_nettype wire

[hdl/nhtl_if.sv]
`default_nettype none
interface nhtl_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  name_byte;
    logic        last_byte;
    logic [14:0] entry_value;
    modport source (output valid, kind, name_byte, last_byte, entry_value, input ready);
    modport sink (input valid, kind, name_byte, last_byte, entry_value, output ready);
endinterface

interface nhtl_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] result_value;
    logic [1:0]         status;
    modport source (output valid, result_value, status, input ready);
    modport sink (input valid, result_value, status, output ready);
endinterface
`default_nettype wire

[hdl/nhtl_ram.sv]
`default_nettype none
module nhtl_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

[hdl/nhtl_name_buf.sv]
`default_nettype none
module nhtl_name_buf import nhtl_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_nb_ctrl         i_ctrl,
    input  wire logic [POS_W-1:0] i_rd_pos,
    output t_nb_stat              o_stat,
    output logic      [7:0]       o_rd_byte
);
    logic [7:0]       r_buf [MAX_NAME_LEN];
    logic [31:0]      r_hash;
    logic [LEN_W-1:0] r_len;
    logic             r_overlong;

    // fnv-1a step, low word of the product only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_hash     <= HASH_BASIS;
            r_len      <= '0;
            r_overlong <= 1'b0;
        end else if (i_ctrl.push) begin
            r_hash <= (r_hash ^ {24'd0, i_ctrl.name_byte}) * HASH_PRIME;
            if (r_len < LEN_W'(MAX_NAME_LEN)) begin
                r_len <= r_len + LEN_W'(1);
            end else begin
                r_overlong <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push && r_len < LEN_W'(MAX_NAME_LEN)) begin
            r_buf[r_len[POS_W-1:0]] <= i_ctrl.name_byte;
        end
    end

    assign o_stat.hash     = r_hash;
    assign o_stat.len      = r_len;
    assign o_stat.overlong = r_overlong;
    assign o_rd_byte       = r_buf[i_rd_pos];
endmodule
`default_nettype wire

[hdl/name_hash_table_lookup.sv]
`default_nettype none
// Name-to-identifier table. Names arrive one byte per item and are hashed
// with 32-bit FNV-1a as they come, one byte per cycle while the table is
// idle. On the last byte the home slot is the hash masked to the slot count
// and a linear probe walks the slot memory: a probe of an occupied slot
// reads the slot, reads the entry, compares the length and then compares
// the name byte by byte against the character memory; a probe that meets an
// empty slot only reads the slot, and an insert of a new name copies its
// bytes into that memory at one byte per cycle. Bytes of the next name are
// not taken until that walk has loaded its result item.
// After reset the slot memory is cleared, one slot per cycle; no byte is
// taken meanwhile.
// Lookups answer the identifier with status 0, or -1 with status 1; inserts
// answer -1 with status 0 (stored), 1 (duplicate kept), 2 (full) or
// 3 (name too long).
module name_hash_table_lookup import nhtl_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    nhtl_in_if.sink  i_in,
    nhtl_out_if.source o_out
);
    t_state r_state, n_state;

    // walk registers
    logic [SLOT_W-1:0] r_clr, n_clr;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [SLOT_W-1:0] r_probe, n_probe;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [POS_W-1:0]  r_k, n_k;
    logic              r_kind, n_kind;
    logic [ID_W-1:0]   r_value, n_value;
    logic [CNT_W-1:0]  r_count, n_count;
    logic signed [RES_W-1:0] r_res_value, n_res_value;
    logic [1:0]        r_res_status, n_res_status;

    // output register
    logic              r_out_valid, n_out_valid;
    logic signed [RES_W-1:0] r_out_value, n_out_value;
    logic [1:0]        r_out_status, n_out_status;
    logic              w_load;

    // memory ports
    logic               slot_we, slot_re;
    logic [SLOT_W-1:0]  slot_waddr;
    logic [SLOTV_W-1:0] slot_wdata, slot_rdata;
    logic               meta_we, meta_re;
    logic [IDX_W-1:0]   meta_raddr;
    logic [ID_W-1:0]    id_rdata;
    logic [LEN_W-1:0]   len_rdata;
    logic               chr_we, chr_re;
    logic [CHAR_AW-1:0] chr_waddr, chr_raddr;
    logic [7:0]         chr_rdata;
    logic [CHAR_AW-1:0] w_base;

    t_nb_ctrl          nb_ctrl;
    t_nb_stat          nb_stat;
    logic [7:0]        nb_byte;

    logic w_accept;
    logic w_last_pos;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    // start of the entry's row in the character memory
    assign w_base     = CHAR_AW'(r_idx) * CHAR_AW'(MAX_NAME_LEN);
    assign w_last_pos = (LEN_W'(r_k) + LEN_W'(1)) == nb_stat.len;

    nhtl_name_buf u_name_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (nb_ctrl),
        .i_rd_pos  (r_k),
        .o_stat    (nb_stat),
        .o_rd_byte (nb_byte)
    );

    // slot memory: entry index plus one, zero means empty
    nhtl_ram #(.DEPTH(SLOT_COUNT), .WIDTH(SLOTV_W)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_re    (slot_re),
        .i_raddr (r_slot),
        .o_rdata (slot_rdata)
    );

    nhtl_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(ID_W)) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (r_idx),
        .i_wdata (r_value),
        .i_re    (meta_re),
        .i_raddr (meta_raddr),
        .o_rdata (id_rdata)
    );

    nhtl_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(LEN_W)) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (r_idx),
        .i_wdata (nb_stat.len),
        .i_re    (meta_re),
        .i_raddr (meta_raddr),
        .o_rdata (len_rdata)
    );

    nhtl_ram #(.DEPTH(MAX_ENTRIES * MAX_NAME_LEN), .WIDTH(8)) u_chr_ram (
        .i_clk   (i_clk),
        .i_we    (chr_we),
        .i_waddr (chr_waddr),
        .i_wdata (nb_byte),
        .i_re    (chr_re),
        .i_raddr (chr_raddr),
        .o_rdata (chr_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_slot       <= n_slot;
        r_probe      <= n_probe;
        r_idx        <= n_idx;
        r_k          <= n_k;
        r_kind       <= n_kind;
        r_value      <= n_value;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_slot       = r_slot;
        n_probe      = r_probe;
        n_idx        = r_idx;
        n_k          = r_k;
        n_kind       = r_kind;
        n_value      = r_value;
        n_count      = r_count;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        w_load       = 1'b0;

        slot_we    = 1'b0;
        slot_re    = 1'b0;
        slot_waddr = r_slot;
        slot_wdata = '0;
        meta_we    = 1'b0;
        meta_re    = 1'b0;
        meta_raddr = r_idx;
        chr_we     = 1'b0;
        chr_re     = 1'b0;
        chr_waddr  = w_base + CHAR_AW'(r_k);
        chr_raddr  = w_base;

        nb_ctrl.push      = w_accept;
        nb_ctrl.clear     = 1'b0;
        nb_ctrl.name_byte = i_in.name_byte;

        unique case (r_state)
            S_CLEAR: begin
                // one slot per cycle back to empty
                slot_we    = 1'b1;
                slot_waddr = r_clr;
                n_clr      = r_clr + SLOT_W'(1);
                if (r_clr == SLOT_W'(SLOT_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept && i_in.last_byte) begin
                    n_kind  = i_in.kind;
                    n_value = i_in.entry_value;
                    n_state = S_START;
                end
            end
            S_START: begin
                if (nb_stat.overlong) begin
                    n_res_value  = RES_NONE;
                    n_res_status = (r_kind == KIND_INSERT) ? ST_LONG : ST_DUP;
                    n_state      = S_DONE;
                end else begin
                    n_slot  = nb_stat.hash[SLOT_W-1:0];
                    n_probe = '0;
                    n_state = S_SLOT_RD;
                end
            end
            S_SLOT_RD: begin
                slot_re = 1'b1;
                n_state = S_SLOT_CHK;
            end
            S_SLOT_CHK: begin
                if (slot_rdata == '0) begin
                    n_res_value = RES_NONE;
                    if (r_kind == KIND_LOOKUP) begin
                        n_res_status = ST_DUP;
                        n_state      = S_DONE;
                    end else if (r_count < CNT_W'(MAX_ENTRIES)) begin
                        n_idx   = r_count[IDX_W-1:0];
                        n_k     = '0;
                        n_state = S_COPY;
                    end else begin
                        n_res_status = ST_FULL;
                        n_state      = S_DONE;
                    end
                end else begin
                    meta_re    = 1'b1;
                    meta_raddr = IDX_W'(slot_rdata - SLOTV_W'(1));
                    n_idx      = meta_raddr;
                    n_state    = S_LEN_CHK;
                end
            end
            S_LEN_CHK: begin
                if (len_rdata != nb_stat.len) begin
                    n_state = S_SLOT_RD;
                end else begin
                    chr_re  = 1'b1;
                    n_k     = '0;
                    n_state = S_CHR_CHK;
                end
            end
            S_CHR_CHK: begin
                if (chr_rdata != nb_byte) begin
                    n_state = S_SLOT_RD;
                end else if (w_last_pos) begin
                    if (r_kind == KIND_LOOKUP) begin
                        n_res_value  = $signed({1'b0, id_rdata});
                        n_res_status = ST_OK;
                    end else begin
                        n_res_value  = RES_NONE;
                        n_res_status = ST_DUP;
                    end
                    n_state = S_DONE;
                end else begin
                    n_k       = r_k + POS_W'(1);
                    chr_re    = 1'b1;
                    chr_raddr = w_base + CHAR_AW'(r_k) + CHAR_AW'(1);
                end
            end
            S_COPY: begin
                chr_we = 1'b1;
                n_k    = r_k + POS_W'(1);
                if (w_last_pos) begin
                    meta_we      = 1'b1;
                    slot_we      = 1'b1;
                    slot_waddr   = r_slot;
                    slot_wdata   = SLOTV_W'(r_idx) + SLOTV_W'(1);
                    n_count      = r_count + CNT_W'(1);
                    n_res_value  = RES_NONE;
                    n_res_status = ST_OK;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    w_load        = 1'b1;
                    nb_ctrl.clear = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a mismatch moves on to the next slot, or ends after a full lap
        if ((r_state == S_LEN_CHK && len_rdata != nb_stat.len) ||
            (r_state == S_CHR_CHK && chr_rdata != nb_byte)) begin
            if (r_probe == SLOT_W'(SLOT_COUNT - 1)) begin
                n_res_value  = RES_NONE;
                n_res_status = (r_kind == KIND_LOOKUP) ? ST_DUP : ST_FULL;
                n_state      = S_DONE;
            end else begin
                n_probe = r_probe + SLOT_W'(1);
                n_slot  = r_slot + SLOT_W'(1);
            end
        end
    end

    always_comb begin
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_valid  = r_out_valid && !o_out.ready;
        if (w_load) begin
            n_out_valid  = 1'b1;
            n_out_value  = r_res_value;
            n_out_status = r_res_status;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_value = r_out_value;
    assign o_out.status       = r_out_status;
endmodule
`default_nettype wire

[hdl/nhtl_checker.sv]
`default_nettype none
module nhtl_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] i_out_value,
    input wire logic [1:0]  i_out_status
);
    // a waiting result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    // every item with a nonzero status answers -1
    a_none_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status != 2'd0 |-> i_out_value == 16'hFFFF)
        else $error("failed item carries an identifier");

    // identifiers are 15 bits, or the -1 marker
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_out_value[15] || i_out_value == 16'hFFFF)
        else $error("identifier out of range");

    // slot clearing keeps the input closed straight after reset
    a_clear_closed: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_in_ready && !i_out_valid)
        else $error("input open during slot clearing");
endmodule

bind name_hash_table_lookup nhtl_checker u_nhtl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_value  (o_out.result_value),
    .i_out_status (o_out.status)
);
`default_nettype wire
